>>> rtl/scoped_symbol_table_unit_assert.svh
// Assertion macros for the scoped symbol table unit.
// Used by modules that include this header; they expect clk and arst_n in scope.
`ifndef SCOPED_SYMBOL_TABLE_UNIT_ASSERT_SVH
`define SCOPED_SYMBOL_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SST_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scoped symbol table check failed");

// Next-cycle implication, checked outside reset.
`define SST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scoped symbol table check failed");

`endif

>>> rtl/sst_pkg.sv
// Shared types and codes of the scoped symbol table unit.
// No dependencies; used by the cell, the top level and the testbench.
package sst_pkg;

	typedef enum logic [1:0] {
		CMD_ENTER  = 2'd0,
		CMD_EXIT   = 2'd1,
		CMD_INSERT = 2'd2,
		CMD_LOOKUP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DUP      = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Partial search result handed from cell to cell.
	typedef struct packed {
		logic       hit;
		logic       dup;
		logic [2:0] dtype;
		logic       func;
		logic [7:0] level;
	} hit_t;

	// Broadcast write of one entry.
	typedef struct packed {
		logic       en;
		logic [2:0] dtype;
		logic       func;
		logic [7:0] level;
	} ent_wr_t;

endpackage

>>> rtl/sst_if.sv
// Request and result channel interfaces of the scoped symbol table unit.
// No dependencies beyond the language.
interface sst_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [47:0] name_key;
	logic [2:0]  data_type;
	logic        is_function;

	modport source (output valid, cmd, name_key, data_type, is_function, input ready);
	modport sink (input valid, cmd, name_key, data_type, is_function, output ready);
endinterface

interface sst_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [2:0] found_type;
	logic       found_is_function;
	logic [7:0] found_level;
	logic [7:0] found_index;
	logic [7:0] level_now;
	logic [8:0] entries_now;

	modport source (output valid, status, found_type, found_is_function, found_level,
		found_index, level_now, entries_now, input ready);
	modport sink (input valid, status, found_type, found_is_function, found_level,
		found_index, level_now, entries_now, output ready);
endinterface

>>> rtl/scoped_symbol_table_unit.sv
// Scoped symbol table unit. Commands are taken one at a time on the req channel and each
// returns exactly one result on the res channel. Enter scope goes to the finish state,
// exit scope via an exit state (the popped mark is read from a registered mark memory),
// and insert and lookup sweep the table: every table entry lives in its own cell of a
// chain, and the search result moves one cell along that chain per cycle, so the
// length of the chain sets the time of a search. A result waits in an output register
// until it is taken; a new request is taken once the previous command has finished.
// There is no clearing pass after reset: the entry count and mark pointer start at zero
// and only entries and marks below them are ever used.
// Depends on sst_pkg, sst_if.sv, sst_cell.sv and scoped_symbol_table_unit_assert.svh.
`include "scoped_symbol_table_unit_assert.svh"

module scoped_symbol_table_unit #(
	parameter int TABLE_DEPTH = 256,
	parameter int SCOPE_DEPTH = 16,
	parameter int KEY_BITS    = 48
) (
	input logic       clk,
	input logic       arst_n,
	sst_req_if.sink   req,
	sst_res_if.source res
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int SW = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
	localparam int TW = $clog2(SCOPE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXIT,
		S_SWEEP,
		S_FINISH
	} state_t;

	state_t              state_q;
	sst_pkg::cmd_t       cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [2:0]          dtype_q;
	logic                func_q;
	logic [CW-1:0]       count_q;
	logic [7:0]          level_q;
	logic [TW-1:0]       top_q;
	logic [CW-1:0]       sweep_q;
	logic [CW-1:0]       mark_rd_q;
	logic [CW-1:0]       marks [SCOPE_DEPTH];

	// Pending result, loaded into the output register when it is free.
	sst_pkg::status_t    status_q;
	logic [2:0]          ftype_q;
	logic                ffunc_q;
	logic [7:0]          flevel_q;
	logic [IW-1:0]       findex_q;

	logic                out_valid_q;
	logic                accept;
	logic                eval;
	logic [63:0]         key_ext;
	sst_pkg::ent_wr_t    wr;
	sst_pkg::hit_t       link_hit [TABLE_DEPTH + 1];
	logic [IW-1:0]       link_idx [TABLE_DEPTH + 1];

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign key_ext   = {16'd0, req.name_key};

	// The search has reached the end of the chain once the sweep counter reaches the depth.
	assign eval = (state_q == S_SWEEP) && (sweep_q == CW'(TABLE_DEPTH));

	// A successful insert writes straight into the cell at the live count.
	always_comb begin
		wr.en    = eval && cmd_q == sst_pkg::CMD_INSERT && !link_hit[TABLE_DEPTH].dup
			&& count_q < CW'(TABLE_DEPTH);
		wr.dtype = dtype_q;
		wr.func  = func_q;
		wr.level = level_q;
	end

	assign link_hit[0] = '0;
	assign link_idx[0] = '0;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		sst_cell #(
			.INDEX    (g),
			.KEY_BITS (KEY_BITS),
			.IW       (IW),
			.CW       (CW)
		) u_cell (
			.clk       (clk),
			.wr        (wr),
			.wr_idx    (count_q[IW-1:0]),
			.wr_key    (key_q),
			.cmp_key   (key_q),
			.cmp_level (level_q),
			.count     (count_q),
			.in_hit    (link_hit[g]),
			.in_idx    (link_idx[g]),
			.out_hit   (link_hit[g+1]),
			.out_idx   (link_idx[g+1])
		);
	end

	// Mark stack memory: pushed on enter, read in the cycle before the pop on exit.
	always_ff @(posedge clk) begin
		if (accept && req.cmd == sst_pkg::CMD_ENTER && top_q < TW'(SCOPE_DEPTH)) begin
			marks[top_q[SW-1:0]] <= count_q;
		end
		if (accept && req.cmd == sst_pkg::CMD_EXIT && top_q != '0) begin
			mark_rd_q <= marks[SW'(top_q - TW'(1))];
		end
	end

	// Request capture and pending result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= sst_pkg::cmd_t'(req.cmd);
			key_q    <= key_ext[KEY_BITS-1:0];
			dtype_q  <= req.data_type;
			func_q   <= req.is_function;
			status_q <= sst_pkg::ST_OK;
			ftype_q  <= '0;
			ffunc_q  <= 1'b0;
			flevel_q <= '0;
			findex_q <= '0;
		end else if (eval) begin
			if (cmd_q == sst_pkg::CMD_INSERT) begin
				if (link_hit[TABLE_DEPTH].dup) begin
					status_q <= sst_pkg::ST_DUP;
				end else if (count_q >= CW'(TABLE_DEPTH)) begin
					status_q <= sst_pkg::ST_FULL;
				end
			end else if (link_hit[TABLE_DEPTH].hit) begin
				ftype_q  <= link_hit[TABLE_DEPTH].dtype;
				ffunc_q  <= link_hit[TABLE_DEPTH].func;
				flevel_q <= link_hit[TABLE_DEPTH].level;
				findex_q <= link_idx[TABLE_DEPTH];
			end else begin
				status_q <= sst_pkg::ST_NOTFOUND;
			end
		end
	end

	// Control state, table counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			level_q     <= '0;
			top_q       <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The output register empties once its result is taken, unless the
			// finishing command loads a fresh one in the same cycle.
			if (res.ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						sweep_q <= '0;
						case (sst_pkg::cmd_t'(req.cmd))
							sst_pkg::CMD_ENTER: begin
								if (level_q != 8'hFF) begin
									level_q <= level_q + 8'd1;
								end
								if (top_q < TW'(SCOPE_DEPTH)) begin
									top_q <= top_q + TW'(1);
								end
								state_q <= S_FINISH;
							end
							sst_pkg::CMD_EXIT: begin
								state_q <= S_EXIT;
							end
							default: begin
								state_q <= S_SWEEP;
							end
						endcase
					end
				end
				S_EXIT: begin
					if (top_q != '0) begin
						top_q <= top_q - TW'(1);
						if (mark_rd_q < count_q) begin
							count_q <= mark_rd_q;
						end
					end
					if (level_q != '0) begin
						level_q <= level_q - 8'd1;
					end
					state_q <= S_FINISH;
				end
				S_SWEEP: begin
					if (eval) begin
						if (wr.en) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_FINISH;
					end else begin
						sweep_q <= sweep_q + CW'(1);
					end
				end
				S_FINISH: begin
					if (!out_valid_q || res.ready) begin
						out_valid_q           <= 1'b1;
						res.status            <= status_q;
						res.found_type        <= ftype_q;
						res.found_is_function <= ffunc_q;
						res.found_level       <= flevel_q;
						res.found_index       <= 8'(findex_q);
						res.level_now         <= level_q;
						res.entries_now       <= 9'(count_q);
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid = out_valid_q;

	// A successful insert grows the table by exactly one entry.
	`SST_ASSERT_NEXT(a_insert_grows, wr.en, count_q == $past(count_q) + CW'(1))
	// A search starts with an empty sweep counter.
	`SST_ASSERT_NEXT(a_search_starts, accept && req.cmd[1], state_q == S_SWEEP && sweep_q == '0)
	// The sweep does not end before the result has crossed the whole chain.
	`SST_ASSERT_NEXT(a_sweep_holds, state_q == S_SWEEP && !eval, state_q == S_SWEEP)
	// Outside the idle state, the live count never passes the table depth.
	`SST_ASSERT_NOW(a_count_bound, state_q != S_IDLE, count_q <= CW'(TABLE_DEPTH))

endmodule

>>> rtl/sst_cell.sv
// One cell of the symbol chain: holds one table entry and folds it into the
// search result passed along the chain. Depends on sst_pkg.
module sst_cell #(
	parameter int INDEX    = 0,
	parameter int KEY_BITS = 48,
	parameter int IW       = 8,
	parameter int CW       = 9
) (
	input  logic                  clk,
	input  sst_pkg::ent_wr_t      wr,
	input  logic [IW-1:0]         wr_idx,
	input  logic [KEY_BITS-1:0]   wr_key,
	input  logic [KEY_BITS-1:0]   cmp_key,
	input  logic [7:0]            cmp_level,
	input  logic [CW-1:0]         count,
	input  sst_pkg::hit_t         in_hit,
	input  logic [IW-1:0]         in_idx,
	output sst_pkg::hit_t         out_hit,
	output logic [IW-1:0]         out_idx
);

	logic [KEY_BITS-1:0] key_q;
	logic [2:0]          dtype_q;
	logic                func_q;
	logic [7:0]          level_q;
	logic                match;

	always_ff @(posedge clk) begin
		if (wr.en && wr_idx == IW'(INDEX)) begin
			key_q   <= wr_key;
			dtype_q <= wr.dtype;
			func_q  <= wr.func;
			level_q <= wr.level;
		end
	end

	// Only entries below the live count take part.
	assign match = (CW'(INDEX) < count) && (key_q == cmp_key);

	// A later cell is a more recent entry, so its hit overrides the one passed in.
	always_ff @(posedge clk) begin
		out_hit.hit <= in_hit.hit | match;
		out_hit.dup <= in_hit.dup | (match && level_q == cmp_level);
		if (match) begin
			out_hit.dtype <= dtype_q;
			out_hit.func  <= func_q;
			out_hit.level <= level_q;
			out_idx       <= IW'(INDEX);
		end else begin
			out_hit.dtype <= in_hit.dtype;
			out_hit.func  <= in_hit.func;
			out_hit.level <= in_hit.level;
			out_idx       <= in_idx;
		end
	end

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench of the scoped symbol table unit: directed and random requests.
// Depends on sst_pkg, the channel interfaces in sst_if.sv and scoped_symbol_table_unit.
module tb_top;

	// One result as seen on the result channel.
	typedef struct packed {
		sst_pkg::status_t status;
		logic [2:0]       found_type;
		logic             found_is_function;
		logic [7:0]       found_level;
		logic [7:0]       found_index;
		logic [7:0]       level_now;
		logic [8:0]       entries_now;
	} table_result_t;

	// The scoreboard keeps its own copy of the symbol table and the mark stack.
	// Every accepted request is applied to that copy straight away, and the
	// result that it must produce is queued until the block returns one.
	class symbol_scoreboard;
		logic [47:0] keys [256];
		logic [2:0] types [256];
		logic funcs [256];
		logic [7:0] levels [256];
		int unsigned marks [16];
		int unsigned count;
		int unsigned level;
		int unsigned mark_top;
		table_result_t expected_q [$];
		int unsigned mismatches;
		int unsigned checked;

		function void note_request(sst_pkg::cmd_t cmd, logic [47:0] key, logic [2:0] dtype,
			logic func);
			table_result_t r;
			bit dup;
			r = '0;
			r.status = sst_pkg::ST_OK;
			dup = 0;
			case (cmd)
				sst_pkg::CMD_ENTER: begin
					if (level < 255) level++;
					if (mark_top < 16) begin
						marks[mark_top] = count;
						mark_top++;
					end
				end
				sst_pkg::CMD_EXIT: begin
					if (mark_top > 0) begin
						mark_top--;
						if (marks[mark_top] < count) count = marks[mark_top];
					end
					if (level > 0) level--;
				end
				sst_pkg::CMD_INSERT: begin
					for (int i = 0; i < count; i++)
						if (levels[i] == level[7:0] && keys[i] == key) dup = 1;
					if (dup) r.status = sst_pkg::ST_DUP;
					else if (count >= 256) r.status = sst_pkg::ST_FULL;
					else begin
						keys[count] = key;
						types[count] = dtype;
						funcs[count] = func;
						levels[count] = level[7:0];
						count++;
					end
				end
				default: begin
					r.status = sst_pkg::ST_NOTFOUND;
					// The newest live entry with the key wins.
					for (int i = int'(count) - 1; i >= 0; i--) begin
						if (keys[i] == key) begin
							r.status = sst_pkg::ST_OK;
							r.found_type = types[i];
							r.found_is_function = funcs[i];
							r.found_level = levels[i];
							r.found_index = i[7:0];
							break;
						end
					end
				end
			endcase
			r.level_now = level[7:0];
			r.entries_now = count[8:0];
			expected_q.push_back(r);
		endfunction

		function void check_result(table_result_t got);
			table_result_t want;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result with nothing expected: %p", got);
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result %0d expected %p got %p", checked, want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	sst_req_if req_ch ();
	sst_res_if res_ch ();

	scoped_symbol_table_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch)
	);

	symbol_scoreboard sb = new();

	// Idling percentages of the current phase, written by the stimulus only.
	int unsigned send_idle;
	int unsigned recv_stall;
	// A new value of this token asks the receiver for one long hold-off.
	int unsigned hold_token;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned sent;
	logic [47:0] key_pool [8];

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// The receiver samples at the rising edge and decides its ready for the next
	// cycle there as well. A long hold-off, once asked for, is counted down here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result('{sst_pkg::status_t'(res_ch.status), res_ch.found_type,
					res_ch.found_is_function, res_ch.found_level, res_ch.found_index,
					res_ch.level_now, res_ch.entries_now});
			if (hold_token != hold_seen) begin
				hold_seen <= hold_token;
				hold_left <= 1500;
				res_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= recv_stall);
			end
		end
	end

	// Offers one request and returns once the block has taken it. Valid is only
	// lowered when an idle gap is chosen, so back-to-back requests keep it high.
	task automatic send_request(sst_pkg::cmd_t cmd, logic [47:0] key, logic [2:0] dtype,
		logic func);
		if ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= cmd;
		req_ch.name_key <= key;
		req_ch.data_type <= dtype;
		req_ch.is_function <= func;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(cmd, key, dtype, func);
		sent++;
	endtask

	// Mostly keys from a small pool so that duplicates and hits are common.
	function automatic logic [47:0] pick_key();
		if ($urandom_range(99) < 70) return key_pool[$urandom_range(7)];
		return {$urandom(), $urandom()};
	endfunction

	// Sender pauses until every outstanding result has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() > 0) @(posedge clk);
	endtask

	task automatic run_mixed(int unsigned n);
		int unsigned w;
		repeat (n) begin
			w = $urandom_range(99);
			if (w < 15)
				send_request(sst_pkg::CMD_ENTER, pick_key(), 3'($urandom), 1'($urandom));
			else if (w < 27)
				send_request(sst_pkg::CMD_EXIT, pick_key(), 3'($urandom), 1'($urandom));
			else if (w < 67)
				send_request(sst_pkg::CMD_INSERT, pick_key(), 3'($urandom), 1'($urandom));
			else
				send_request(sst_pkg::CMD_LOOKUP, pick_key(), 3'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= sst_pkg::CMD_ENTER;
		req_ch.name_key <= '0;
		req_ch.data_type <= '0;
		req_ch.is_function <= 1'b0;
		send_idle = 0;
		recv_stall = 0;
		hold_token = 0;
		sent = 0;
		key_pool = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h1, 48'h8000_0000_0000,
			48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h1234, 48'h1235};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: empty table, exit without a mark, duplicates, shadowing
		// across levels, unused type codes and dropping entries on exit.
		send_request(sst_pkg::CMD_LOOKUP, 48'h0, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_EXIT, 48'h0, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_INSERT, 48'h0, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_INSERT, 48'h0, 3'd5, 1'b1);
		send_request(sst_pkg::CMD_INSERT, 48'hFFFF_FFFF_FFFF, 3'd7, 1'b1);
		send_request(sst_pkg::CMD_INSERT, 48'h8000_0000_0001, 3'd6, 1'b0);
		send_request(sst_pkg::CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_LOOKUP, 48'h0, 3'd7, 1'b1);
		send_request(sst_pkg::CMD_ENTER, 48'h0, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_INSERT, 48'h0, 3'd4, 1'b1);
		send_request(sst_pkg::CMD_LOOKUP, 48'h0, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_INSERT, 48'h0, 3'd2, 1'b0);
		send_request(sst_pkg::CMD_ENTER, 48'h0, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_INSERT, 48'h8000_0000_0001, 3'd3, 1'b1);
		send_request(sst_pkg::CMD_EXIT, 48'h0, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_LOOKUP, 48'h8000_0000_0001, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_EXIT, 48'h0, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_LOOKUP, 48'h0, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_LOOKUP, 48'h7FFF_FFFF_FFFE, 3'd0, 1'b0);
		drain();

		// Random part, once under each idling pattern. During the first stalled
		// phase the receiver holds off for a long stretch so the block backs up.
		for (int p = 0; p < 4; p++) begin
			send_idle = (p == 1) ? 57 : (p == 3) ? 12 : 0;
			recv_stall = (p == 2) ? 57 : (p == 3) ? 12 : 0;
			if (p == 2) hold_token++;
			run_mixed(20);
			drain();
		end

		// Fill the table from inside a fresh scope, then try inserts into a full
		// table, both a duplicate and a new name, before dropping the scope.
		send_idle = 0;
		recv_stall = 0;
		send_request(sst_pkg::CMD_ENTER, 48'h0, 3'd0, 1'b0);
		while (sb.count < 256)
			send_request(sst_pkg::CMD_INSERT, {$urandom(), $urandom()}, 3'($urandom),
				1'($urandom));
		send_request(sst_pkg::CMD_INSERT, sb.keys[255], 3'd1, 1'b0);
		send_request(sst_pkg::CMD_INSERT, 48'h0000_DEAD_0001, 3'd1, 1'b0);
		send_request(sst_pkg::CMD_INSERT, 48'h0000_DEAD_0002, 3'd2, 1'b1);
		send_request(sst_pkg::CMD_LOOKUP, sb.keys[255], 3'd0, 1'b0);
		send_request(sst_pkg::CMD_LOOKUP, sb.keys[0], 3'd0, 1'b0);
		send_request(sst_pkg::CMD_EXIT, 48'h0, 3'd0, 1'b0);
		send_request(sst_pkg::CMD_LOOKUP, 48'h0, 3'd0, 1'b0);
		drain();

		// Nest deeper than the mark stack so that it overflows, then exit more times
		// than it entered.
		send_idle = 12;
		recv_stall = 12;
		repeat (20)
			send_request(sst_pkg::CMD_ENTER, pick_key(), 3'($urandom), 1'($urandom));
		send_request(sst_pkg::CMD_INSERT, 48'h1, 3'd3, 1'b1);
		send_request(sst_pkg::CMD_LOOKUP, 48'h1, 3'd0, 1'b0);
		repeat (22)
			send_request(sst_pkg::CMD_EXIT, pick_key(), 3'($urandom), 1'($urandom));

		drain();
		repeat (300) @(posedge clk);
		$display("Sent %0d requests and checked %0d results, covering a full table,", sent,
			sb.checked);
		$display("mark stack overflow, exits below level zero and a long receiver hold-off.");
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("Mismatches: %0d, results still expected: %0d", sb.mismatches,
				sb.expected_q.size());
			$display("tb_top NOT OK");
		end
		$finish;
	end

	// Generous time limit for the whole run.
	initial begin
		#(8 * 4000000);
		$display("Timed out with %0d results still expected", sb.expected_q.size());
		$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> scoped_symbol_table_unit.f
+incdir+rtl
rtl/sst_pkg.sv
rtl/sst_if.sv
rtl/sst_cell.sv
rtl/scoped_symbol_table_unit.sv
tb/sv/tb_top.sv
